// File: src/tlsm_pkg.sv
package tlsm_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned KEY_WIDTH_DEF  = 32;

  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned KEY_VALUE_W = 32;
  localparam int unsigned MERGED_W    = 32;
  localparam int unsigned MODE_W      = 2;

  localparam int unsigned MODE_DESC_BIT   = 0;
  localparam int unsigned MODE_SIGNED_BIT = 1;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_APPEND_FIRST  = 2'd0,
    REQ_APPEND_SECOND = 2'd1,
    REQ_RUN           = 2'd2
  } req_type_e;

endpackage

// File: src/tlsm_if.sv
interface tlsm_req_if;
  logic                               valid;
  logic                               ready;
  logic [tlsm_pkg::REQ_TYPE_W-1:0]    req_type;
  logic [tlsm_pkg::KEY_VALUE_W-1:0]   key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface tlsm_res_if;
  logic                            valid;
  logic                            ready;
  logic [tlsm_pkg::MERGED_W-1:0]   merged_key;
  logic                            from_second;
  logic                            last;

  modport source (output valid, output merged_key, output from_second, output last,
                  input ready);
  modport sink   (input valid, input merged_key, input from_second, input last,
                  output ready);
endinterface

interface tlsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tlsm_pkg::MODE_W-1:0]   order_mode;

  modport source (output valid, output order_mode, input ready);
  modport sink   (input valid, input order_mode, output ready);
endinterface

// File: src/two_list_sorted_merge_unit.sv
// A request is taken every cycle while idle.
// A run fetches both list heads, then emits one key per cycle while the result
// register is free or being taken, from the two list memories (one registered
// read port each); no request is taken until the run's last key is emitted.
// Reset (asynchronous, active low) clears both counts, the order mode and the
// result valid flag; list contents are kept and hold no meaning until appended.
module two_list_sorted_merge_unit #(
  parameter int unsigned LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = tlsm_pkg::KEY_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlsm_cfg_if.sink   cfg_i,
  tlsm_req_if.sink   req_i,
  tlsm_res_if.source res_o
);

  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam logic [KEY_WIDTH-1:0] KeySign = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                         state_q, state_d;
  logic [tlsm_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [CntW-1:0]              cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0]              idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [KEY_WIDTH-1:0]         key_in, head_a, head_b, cmp_a, cmp_b;
  logic                         wr_a, wr_b, req_fire, out_free;
  logic                         goes_a, take_a, last_a, last_b;
  logic                         res_valid_q, res_valid_d;
  logic                         res_src_q, res_src_d, res_last_q, res_last_d;
  logic [tlsm_pkg::MERGED_W-1:0] res_key_q, res_key_d, head_out;
  logic [KEY_WIDTH-1:0]         head_sel;

  generate
    if (KEY_WIDTH <= tlsm_pkg::KEY_VALUE_W) begin : g_key_narrow
      assign key_in = req_i.key_value[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign key_in = {{(KEY_WIDTH - tlsm_pkg::KEY_VALUE_W){1'b0}}, req_i.key_value};
    end
    if (KEY_WIDTH >= tlsm_pkg::MERGED_W) begin : g_out_trunc
      assign head_out = head_sel[tlsm_pkg::MERGED_W-1:0];
    end else begin : g_out_ext
      assign head_out = {{(tlsm_pkg::MERGED_W - KEY_WIDTH){1'b0}}, head_sel};
    end
  endgenerate

  tlsm_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(KEY_WIDTH), .ADDR_W(AddrW)) u_first_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a),
    .wr_addr_i (cnt_a_q[AddrW-1:0]),
    .wr_data_i (key_in),
    .rd_addr_i (idx_a_d[AddrW-1:0]),
    .rd_data_o (head_a)
  );

  tlsm_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(KEY_WIDTH), .ADDR_W(AddrW)) u_second_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b),
    .wr_addr_i (cnt_b_q[AddrW-1:0]),
    .wr_data_i (key_in),
    .rd_addr_i (idx_b_d[AddrW-1:0]),
    .rd_data_o (head_b)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;

  assign cmp_a  = head_a ^ (mode_q[tlsm_pkg::MODE_SIGNED_BIT] ? KeySign : '0);
  assign cmp_b  = head_b ^ (mode_q[tlsm_pkg::MODE_SIGNED_BIT] ? KeySign : '0);
  assign goes_a = mode_q[tlsm_pkg::MODE_DESC_BIT] ? (cmp_a >= cmp_b) : (cmp_a <= cmp_b);
  assign take_a = (idx_b_q >= cnt_b_q) || ((idx_a_q < cnt_a_q) && goes_a);
  assign last_a = ((idx_a_q + CntW'(1)) == cnt_a_q) && (idx_b_q == cnt_b_q);
  assign last_b = ((idx_b_q + CntW'(1)) == cnt_b_q) && (idx_a_q == cnt_a_q);
  assign head_sel = take_a ? head_a : head_b;

  assign mode_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.order_mode : mode_q;

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    res_valid_d = res_valid_q && !res_o.ready;
    res_key_d   = res_key_q;
    res_src_d   = res_src_q;
    res_last_d  = res_last_q;
    case (state_q)
      StIdle: begin
        idx_a_d = '0;
        idx_b_d = '0;
        if (req_fire) begin
          case (req_i.req_type)
            tlsm_pkg::REQ_APPEND_FIRST: begin
              if (cnt_a_q < CntW'(LIST_DEPTH)) begin
                wr_a    = 1'b1;
                cnt_a_d = cnt_a_q + CntW'(1);
              end
            end
            tlsm_pkg::REQ_APPEND_SECOND: begin
              if (cnt_b_q < CntW'(LIST_DEPTH)) begin
                wr_b    = 1'b1;
                cnt_b_d = cnt_b_q + CntW'(1);
              end
            end
            tlsm_pkg::REQ_RUN: begin
              if ((cnt_a_q != '0) || (cnt_b_q != '0)) begin
                state_d = StRun;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StRun: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          res_key_d   = head_out;
          res_src_d   = !take_a;
          res_last_d  = take_a ? last_a : last_b;
          if (take_a) begin
            idx_a_d = idx_a_q + CntW'(1);
          end else begin
            idx_b_d = idx_b_q + CntW'(1);
          end
          if (take_a ? last_a : last_b) begin
            state_d = StIdle;
            cnt_a_d = '0;
            cnt_b_d = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= '0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_key_q  <= res_key_d;
    res_src_q  <= res_src_d;
    res_last_q <= res_last_d;
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.merged_key  = res_key_q;
  assign res_o.from_second = res_src_q;
  assign res_o.last        = res_last_q;

endmodule

// File: src/tlsm_list_mem.sv
module tlsm_list_mem #(
  parameter int unsigned DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned WIDTH = tlsm_pkg::KEY_WIDTH_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: tb/two_list_sorted_merge_unit_tb.sv
`timescale 1ns / 100ps

module two_list_sorted_merge_unit_tb;
  import tlsm_pkg::*;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned RANDOM_REQUESTS = 75;

  typedef struct packed {
    logic [MERGED_W-1:0] key;
    logic                from_second;
    logic                last;
  } merged_t;

  typedef enum int {RX_STEADY, RX_LIGHT, RX_ONE_IN_THREE, RX_HEAVY} rx_pattern_e;

  class merge_scoreboard;
    logic [MODE_W-1:0]      order_mode;
    logic [KEY_VALUE_W-1:0] first_keys[$];
    logic [KEY_VALUE_W-1:0] second_keys[$];
    merged_t                due[$];
    int unsigned            mismatches;
    int unsigned            requests_seen;
    int unsigned            runs_seen;
    int unsigned            keys_checked;

    function new();
      order_mode = '0;
      mismatches = 0;
      requests_seen = 0;
      runs_seen = 0;
      keys_checked = 0;
    endfunction

    static function bit first_leads(logic [KEY_VALUE_W-1:0] a, logic [KEY_VALUE_W-1:0] b,
                                    logic [MODE_W-1:0] mode);
      logic [KEY_VALUE_W-1:0] x;
      logic [KEY_VALUE_W-1:0] y;
      x = a;
      y = b;
      if (mode[MODE_SIGNED_BIT]) begin
        x[KEY_VALUE_W-1] = ~x[KEY_VALUE_W-1];
        y[KEY_VALUE_W-1] = ~y[KEY_VALUE_W-1];
      end
      return mode[MODE_DESC_BIT] ? (x >= y) : (x <= y);
    endfunction

    function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [KEY_VALUE_W-1:0] key);
      int      i;
      int      j;
      int      total;
      merged_t r;
      requests_seen++;
      if (kind == REQ_APPEND_FIRST) begin
        if (first_keys.size() < LIST_DEPTH_DEF) first_keys.push_back(key);
      end else if (kind == REQ_APPEND_SECOND) begin
        if (second_keys.size() < LIST_DEPTH_DEF) second_keys.push_back(key);
      end else if (kind == REQ_RUN) begin
        i = 0;
        j = 0;
        total = first_keys.size() + second_keys.size();
        while (i < first_keys.size() || j < second_keys.size()) begin
          if (j >= second_keys.size() ||
              (i < first_keys.size() && first_leads(first_keys[i], second_keys[j], order_mode)))
          begin
            r.key = first_keys[i];
            r.from_second = 1'b0;
            i++;
          end else begin
            r.key = second_keys[j];
            r.from_second = 1'b1;
            j++;
          end
          r.last = (i + j == total);
          due.push_back(r);
        end
        first_keys.delete();
        second_keys.delete();
        runs_seen++;
      end
    endfunction

    function void check_result(merged_t got);
      merged_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected merged key %h src %0d last %0d", $realtime, got.key,
                   got.from_second, got.last);
        return;
      end
      want = due.pop_front();
      keys_checked++;
      if (got.key !== want.key || got.from_second !== want.from_second ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: want key %h src %0d last %0d, got key %h src %0d last %0d",
                   $realtime, want.key, want.from_second, want.last, got.key, got.from_second,
                   got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlsm_cfg_if cfg_bus();
  tlsm_req_if req_bus();
  tlsm_res_if res_bus();

  two_list_sorted_merge_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  merge_scoreboard sb = new();

  logic [MODE_W-1:0] cur_mode = '0;
  int unsigned       burst_left = 0;
  int unsigned       requests_offered = 0;
  int unsigned       mode_writes = 0;
  bit                gaps_on = 1'b1;
  bit                hold_request = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       rx_tick = 0;
  rx_pattern_e       rx_pattern = RX_STEADY;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.order_mode = cfg_bus.order_mode;
      if (res_bus.valid && res_bus.ready)
        sb.check_result('{res_bus.merged_key, res_bus.from_second, res_bus.last});
      if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.req_type, req_bus.key_value);
    end
  end

  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 160 == 0) rx_pattern = rx_pattern_e'($urandom_range(0, 3));
    if (!rst_n) begin
      res_bus.ready = 1'b0;
    end else if (hold_left != 0) begin
      res_bus.ready = 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      res_bus.ready = 1'b0;
    end else begin
      case (rx_pattern)
        RX_STEADY:       res_bus.ready = 1'b1;
        RX_LIGHT:        res_bus.ready = ($urandom_range(0, 3) != 0);
        RX_ONE_IN_THREE: res_bus.ready = (rx_tick % 3 == 0);
        default:         res_bus.ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                              input logic [KEY_VALUE_W-1:0] key);
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_bus.valid = 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 5))
          @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (kind != REQ_UNUSED) requests_offered++;
    req_bus.valid = 1'b1;
    req_bus.req_type = kind;
    req_bus.key_value = key;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    req_bus.valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_order_mode(input logic [MODE_W-1:0] mode);
    wait_for_drain();
    cfg_bus.valid = 1'b1;
    cfg_bus.order_mode = mode;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    cur_mode = mode;
    mode_writes++;
  endtask

  function automatic logic [KEY_VALUE_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: return 32'h7FFF_FFFC + $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic void build_list(ref logic [KEY_VALUE_W-1:0] q[$], input int n,
                                     input logic [MODE_W-1:0] mode, input bit keep_order);
    logic [KEY_VALUE_W-1:0] t;
    q.delete();
    repeat (n) q.push_back(pick_key());
    if (keep_order) begin
      for (int a = 0; a < n; a++) begin
        for (int b = 0; b + 1 < n - a; b++) begin
          if (!merge_scoreboard::first_leads(q[b], q[b+1], mode)) begin
            t = q[b];
            q[b] = q[b+1];
            q[b+1] = t;
          end
        end
      end
    end
  endfunction

  task automatic load_and_run(input int n1, input int n2, input bit keep_order);
    logic [KEY_VALUE_W-1:0] la[$];
    logic [KEY_VALUE_W-1:0] lb[$];
    int i;
    int j;
    build_list(la, n1, cur_mode, keep_order);
    build_list(lb, n2, cur_mode, keep_order);
    i = 0;
    j = 0;
    while (i < la.size() || j < lb.size()) begin
      if ($urandom_range(0, 19) == 0) send_request(REQ_UNUSED, $urandom());
      if (j >= lb.size() || (i < la.size() && $urandom_range(0, 1) == 1)) begin
        send_request(REQ_APPEND_FIRST, la[i]);
        i++;
      end else begin
        send_request(REQ_APPEND_SECOND, lb[j]);
        j++;
      end
    end
    send_request(REQ_RUN, $urandom());
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned random_start;
    int          n1;
    int          n2;

    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_RUN;
    req_bus.key_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.order_mode = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_order_mode(2'd0);
    send_request(REQ_RUN, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'hA5A5_5A5A);
    send_request(REQ_APPEND_FIRST, 32'h0000_0000);
    send_request(REQ_APPEND_SECOND, 32'h0000_0000);
    send_request(REQ_APPEND_SECOND, 32'h7FFF_FFFF);
    send_request(REQ_APPEND_FIRST, 32'hFFFF_FFFF);
    send_request(REQ_APPEND_SECOND, 32'hFFFF_FFFF);
    send_request(REQ_RUN, 32'h0000_0000);
    send_request(REQ_APPEND_FIRST, 32'h0000_0005);
    send_request(REQ_RUN, 32'h0000_0000);
    send_request(REQ_APPEND_SECOND, 32'h8000_0000);
    send_request(REQ_RUN, 32'h0000_0000);

    set_order_mode(2'd3);
    send_request(REQ_APPEND_FIRST, 32'h7FFF_FFFF);
    send_request(REQ_APPEND_SECOND, 32'h7FFF_FFFF);
    send_request(REQ_APPEND_FIRST, 32'h0000_0000);
    send_request(REQ_APPEND_SECOND, 32'hFFFF_FFFF);
    send_request(REQ_APPEND_FIRST, 32'h8000_0000);
    send_request(REQ_APPEND_SECOND, 32'h8000_0000);
    send_request(REQ_RUN, 32'h0000_0000);

    random_start = requests_offered;
    phase = 0;
    while (requests_offered < random_start + RANDOM_REQUESTS) begin
      if (phase < 4) set_order_mode(phase[MODE_W-1:0]);
      else set_order_mode(MODE_W'($urandom_range(0, 3)));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 11))
          0: begin
            n1 = $urandom_range(28, 35);
            n2 = $urandom_range(0, 4);
          end
          1: begin
            n1 = $urandom_range(0, 4);
            n2 = $urandom_range(28, 35);
          end
          2: begin
            n1 = 0;
            n2 = 0;
          end
          default: begin
            n1 = $urandom_range(0, 6);
            n2 = $urandom_range(0, 6);
          end
        endcase
        load_and_run(n1, n2, $urandom_range(0, 6) != 0);
      end
      phase++;
    end

    // hold the receiver off so the block fills up and stalls further requests
    set_order_mode(2'd3);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    load_and_run(6, 6, 1'b1);
    load_and_run(6, 3, 1'b1);
    wait_for_drain();
    gaps_on = 1'b1;
    load_and_run(3, 5, 1'b1);

    wait_for_drain();
    repeat (20) @(negedge clk);
    $display("covered %0d requests with %0d merge runs over %0d order settings",
             sb.requests_seen, sb.runs_seen, mode_writes);
    $display("checked %0d merged keys, %0d mismatching", sb.keys_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
